@@ sv/dcfd_pkg.sv @@
// Shared constants for the depth column floor detector.
package dcfd_pkg;

  localparam int MaxRows     = 512;
  localparam int CountW      = $clog2(MaxRows);
  localparam int RowsW       = CountW + 1;
  localparam int SumW        = CountW + 8;
  localparam int CfgAddrW    = 4;
  localparam int CfgDataW    = 32;

  localparam logic [7:0] WhiteDepth = 8'hff;

  // register indexes on the configuration port (word address)
  localparam logic [1:0] RegSlopeTol = 2'd0;
  localparam logic [1:0] RegBaseTol  = 2'd1;
  localparam logic [1:0] RegMinRows  = 2'd2;
  localparam logic [1:0] RegWhiteLim = 2'd3;

  // position of the current pixel within its column
  localparam logic [1:0] PosBottom = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosScan   = 2'd2;

  typedef logic [CountW-1:0] count_t;
  typedef logic [SumW-1:0]   dsum_t;

endpackage

@@ sv/depth_column_floor_detector.sv @@
// An accepted pixel waits in the input register and updates the column state when it
// leaves it; a column-end pixel then loads its result into the result register on out_*.
// Throughput: one pixel per cycle; the input stalls only while a column-end pixel
// waits behind a result that the output side has not yet taken.
// Reset (rst_n low, synchronous): configuration back to defaults, column and frame
// state cleared, next column treated as a frame's first column, no result pending.
module depth_column_floor_detector
  import dcfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // pixel channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_depth,
  input  logic                in_column_end,
  input  logic                in_frame_start,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_floor_found,
  output logic [RowsW-1:0]    out_clear_rows,
  output logic [CountW-1:0]   out_plane_rows,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  // configuration registers
  logic [7:0]       slope_tol_r;
  logic [7:0]       base_tol_r;
  logic [RowsW-1:0] min_rows_r;
  logic [RowsW-1:0] white_lim_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_depth_r;
  logic       s1_cend_r;
  logic       s1_fstart_r;

  // column and frame state
  logic [7:0]        prev_r, prev_nxt;
  logic [7:0]        bottom_r, bottom_nxt;
  logic signed [8:0] slope_r, slope_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic              stop_r, stop_nxt;
  count_t            plane_r, plane_nxt;
  count_t            cons_r, cons_nxt;
  count_t            white_r, white_nxt;
  dsum_t             sum_r, sum_nxt;
  logic [7:0]        ref_base_r, ref_base_nxt;
  logic signed [8:0] ref_slope_r, ref_slope_nxt;
  logic              first_r, first_nxt;

  // result register
  logic             out_valid_r;
  logic             found_r, found_nxt;
  logic [RowsW-1:0] clear_r, clear_nxt;
  count_t           plane_out_r;

  logic cfg_write;
  logic out_free;
  logic s1_fire;
  logic in_accept;

  // column state as seen by this pixel (a frame start drops the partial column)
  logic [1:0]        pos_b;
  logic              stop_b;
  count_t            plane_b, cons_b, white_b;
  dsum_t             sum_b;
  logic signed [8:0] slope_b;
  logic              first_b;

  logic signed [8:0] pair_diff;
  logic [7:0]        pair_abs;
  logic signed [9:0] dev;
  logic [8:0]        dev_abs;
  logic              pair_white;
  logic              pair_active;
  logic signed [8:0] ref_slope_e;
  logic [7:0]        ref_base_e;
  logic signed [9:0] slope_dev;
  logic [8:0]        slope_dev_abs;
  logic signed [8:0] base_dev;
  logic [7:0]        base_dev_abs;
  logic              floor_col;
  logic [SumW+4:0]   sum_x20;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      RegSlopeTol: prdata = {{(CfgDataW-8){1'b0}}, slope_tol_r};
      RegBaseTol:  prdata = {{(CfgDataW-8){1'b0}}, base_tol_r};
      RegMinRows:  prdata = {{(CfgDataW-RowsW){1'b0}}, min_rows_r};
      RegWhiteLim: prdata = {{(CfgDataW-RowsW){1'b0}}, white_lim_r};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_tol_r <= 8'd2;
      base_tol_r  <= 8'd2;
      min_rows_r  <= RowsW'(5);
      white_lim_r <= RowsW'(20);
    end else if (cfg_write) begin
      case (paddr[3:2])
        RegSlopeTol: slope_tol_r <= pwdata[7:0];
        RegBaseTol:  base_tol_r  <= pwdata[7:0];
        RegMinRows:  min_rows_r  <= pwdata[RowsW-1:0];
        RegWhiteLim: white_lim_r <= pwdata[RowsW-1:0];
        default: ;
      endcase
    end
  end

  // handshake: only a column-end pixel needs room in the result register
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && (!s1_cend_r || out_free);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept || (s1_valid_r && !s1_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_depth_r  <= in_depth;
      s1_cend_r   <= in_column_end;
      s1_fstart_r <= in_frame_start;
    end
  end

  always_comb begin
    pos_b   = s1_fstart_r ? PosBottom : pos_r;
    stop_b  = s1_fstart_r ? 1'b0 : stop_r;
    plane_b = s1_fstart_r ? '0 : plane_r;
    cons_b  = s1_fstart_r ? '0 : cons_r;
    white_b = s1_fstart_r ? '0 : white_r;
    sum_b   = s1_fstart_r ? '0 : sum_r;
    slope_b = s1_fstart_r ? '0 : slope_r;
    first_b = s1_fstart_r || first_r;

    pair_diff = $signed({1'b0, prev_r}) - $signed({1'b0, s1_depth_r});
    pair_abs  = pair_diff[8] ? 8'(-pair_diff) : pair_diff[7:0];

    bottom_nxt = (pos_b == PosBottom) ? s1_depth_r : bottom_r;
    slope_nxt  = (pos_b == PosSecond) ? pair_diff : slope_b;
    pos_nxt    = (pos_b == PosBottom) ? PosSecond : PosScan;
    prev_nxt   = s1_depth_r;

    dev     = 10'(slope_nxt) - 10'(pair_diff);
    dev_abs = dev[9] ? 9'(-dev) : dev[8:0];

    pair_white  = (prev_r == WhiteDepth) || (s1_depth_r == WhiteDepth);
    pair_active = (pos_b != PosBottom) && !stop_b && (plane_b != count_t'(MaxRows - 1));

    stop_nxt  = stop_b;
    plane_nxt = plane_b;
    cons_nxt  = cons_b;
    white_nxt = white_b;
    sum_nxt   = sum_b;
    if (pair_active) begin
      if (pair_white) begin
        white_nxt = white_b + 1'b1;
        plane_nxt = plane_b + 1'b1;
      end else begin
        sum_nxt = sum_b + SumW'(pair_abs);
        if (dev_abs > {1'b0, slope_tol_r}) begin
          stop_nxt = 1'b1;
        end else begin
          plane_nxt = plane_b + 1'b1;
          // a consistent pair after a long white run ends the plane
          if ((white_b != '0) && ({1'b0, white_b} > white_lim_r)) begin
            stop_nxt = 1'b1;
          end else begin
            cons_nxt = cons_b + 1'b1;
          end
        end
      end
    end

    // column-end decision on the updated column state
    ref_slope_e   = first_b ? slope_nxt : ref_slope_r;
    ref_base_e    = first_b ? bottom_nxt : ref_base_r;
    slope_dev     = 10'(slope_nxt) - 10'(ref_slope_e);
    slope_dev_abs = slope_dev[9] ? 9'(-slope_dev) : slope_dev[8:0];
    base_dev      = $signed({1'b0, ref_base_e}) - $signed({1'b0, bottom_nxt});
    base_dev_abs  = base_dev[8] ? 8'(-base_dev) : base_dev[7:0];

    floor_col = ({1'b0, plane_nxt} >= min_rows_r)
             && (slope_dev_abs <= {1'b0, slope_tol_r})
             && !first_b
             && (base_dev_abs <= base_tol_r);

    sum_x20   = {sum_nxt, 4'b0} + {2'b0, sum_nxt, 2'b0};
    found_nxt = floor_col && (sum_nxt != '0) && (sum_x20 >= (SumW+5)'(cons_nxt));
    clear_nxt = found_nxt ? ({1'b0, cons_nxt} + 1'b1) : '0;

    ref_slope_nxt = ref_slope_e;
    ref_base_nxt  = (floor_col && !found_nxt) ? ref_base_e : bottom_nxt;
    first_nxt     = first_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      bottom_r    <= '0;
      slope_r     <= '0;
      pos_r       <= PosBottom;
      stop_r      <= 1'b0;
      plane_r     <= '0;
      cons_r      <= '0;
      white_r     <= '0;
      sum_r       <= '0;
      ref_base_r  <= '0;
      ref_slope_r <= '0;
      first_r     <= 1'b1;
    end else if (s1_fire) begin
      prev_r   <= prev_nxt;
      bottom_r <= bottom_nxt;
      if (s1_cend_r) begin
        // close the column and start the next one
        ref_base_r  <= ref_base_nxt;
        ref_slope_r <= ref_slope_nxt;
        first_r     <= 1'b0;
        slope_r     <= '0;
        pos_r       <= PosBottom;
        stop_r      <= 1'b0;
        plane_r     <= '0;
        cons_r      <= '0;
        white_r     <= '0;
        sum_r       <= '0;
      end else begin
        first_r <= first_nxt;
        slope_r <= slope_nxt;
        pos_r   <= pos_nxt;
        stop_r  <= stop_nxt;
        plane_r <= plane_nxt;
        cons_r  <= cons_nxt;
        white_r <= white_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_cend_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_cend_r) begin
      found_r     <= found_nxt;
      clear_r     <= clear_nxt;
      plane_out_r <= plane_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_floor_found = found_r;
  assign out_clear_rows  = clear_r;
  assign out_plane_rows  = plane_out_r;

  a_pos_legal: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 2'd3)
    else $error("column position out of range");

  a_counts_fit: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, white_r} + {1'b0, cons_r}) <= {1'b0, plane_r})
    else $error("white and consistent counts exceed plane count");

  a_found_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (found_r == (clear_r != '0)))
    else $error("floor flag and clear count disagree");

  a_clear_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && found_r) |-> (clear_r <= ({1'b0, plane_out_r} + 1'b1)))
    else $error("clear count exceeds plane rows");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_cend_r && out_valid_r && out_stall))
    else $error("input stalled without a held result");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for depth_column_floor_detector: random and directed columns
// against a cycle-free floor predictor.
module tb_top;
  import dcfd_pkg::*;

  localparam int QuietLimit    = 3000;
  localparam int HoldoffCycles = 300;

  typedef struct packed {
    logic [7:0] depth;
    logic       col_end;
    logic       frm_start;
  } pixel_t;

  typedef struct packed {
    logic              floor_found;
    logic [RowsW-1:0]  clear_rows;
    logic [CountW-1:0] plane_rows;
  } floor_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_depth = '0;
  logic                in_column_end = 1'b0;
  logic                in_frame_start = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_floor_found;
  logic [RowsW-1:0]    out_clear_rows;
  logic [CountW-1:0]   out_plane_rows;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  depth_column_floor_detector uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_depth       (in_depth),
    .in_column_end  (in_column_end),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_floor_found(out_floor_found),
    .out_clear_rows (out_clear_rows),
    .out_plane_rows (out_plane_rows),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  pixel_t        pixel_q[$];
  floor_result_t floor_q[$];

  int mismatches = 0;
  int results_seen = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int holdoff_req = 0;
  int holdoff_seen = 0;
  int holdoff_left = 0;
  int quiet_cycles = 0;

  // stimulus scene: current frame's floor
  int  gen_base = 100;
  int  gen_slope = 2;
  bit  need_frame = 1'b1;

  // predictor configuration and state
  logic [7:0]        tol_slope = 8'd2;
  logic [7:0]        tol_base = 8'd2;
  logic [9:0]        min_rows = 10'd5;
  logic [9:0]        white_limit = 10'd20;
  logic [7:0]        prev_px = '0;
  logic [7:0]        bottom_px = '0;
  logic [7:0]        ref_base = '0;
  logic signed [8:0] col_slope = '0;
  logic signed [8:0] ref_slope = '0;
  logic [1:0]        pos = PosBottom;
  logic              halted = 1'b0;
  count_t            pairs_in_plane = '0;
  count_t            steady_pairs = '0;
  count_t            whites = '0;
  dsum_t             abs_sum = '0;
  logic              first_col = 1'b1;

  initial forever #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function automatic int magnitude(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void open_column();
    pos = PosBottom;
    halted = 1'b0;
    pairs_in_plane = '0;
    steady_pairs = '0;
    whites = '0;
    abs_sum = '0;
    col_slope = '0;
  endfunction

  function automatic void scan_pair(input logic [7:0] lower, input logic [7:0] upper);
    int d;
    if (halted || int'(pairs_in_plane) >= MaxRows - 1) return;
    if (lower == WhiteDepth || upper == WhiteDepth) begin
      whites++;
      pairs_in_plane++;
      return;
    end
    d = int'(lower) - int'(upper);
    abs_sum += dsum_t'(magnitude(d));
    if (magnitude(int'(col_slope) - d) > int'(tol_slope)) begin
      halted = 1'b1;
      return;
    end
    pairs_in_plane++;
    // a consistent pair after a long white run ends the plane
    if (whites != 0 && whites > white_limit) begin
      halted = 1'b1;
      return;
    end
    steady_pairs++;
  endfunction

  function automatic bit predict_pixel(input logic [7:0] depth, input logic col_end,
                                       input logic frm_start, output floor_result_t res);
    bit on_floor;
    res = '0;
    if (frm_start) begin
      first_col = 1'b1;
      open_column();
    end
    if (pos == PosBottom) begin
      bottom_px = depth;
      pos = PosSecond;
    end else begin
      if (pos == PosSecond) begin
        col_slope = $signed({1'b0, prev_px}) - $signed({1'b0, depth});
        pos = PosScan;
      end
      scan_pair(prev_px, depth);
    end
    prev_px = depth;
    if (!col_end) return 1'b0;
    if (first_col) begin
      ref_slope = col_slope;
      ref_base = bottom_px;
    end
    on_floor = pairs_in_plane >= min_rows
      && magnitude(int'(col_slope) - int'(ref_slope)) <= int'(tol_slope)
      && !first_col
      && magnitude(int'(ref_base) - int'(bottom_px)) <= int'(tol_base);
    if (on_floor) begin
      if (abs_sum != 0 && 20 * int'(abs_sum) >= int'(steady_pairs)) begin
        res.floor_found = 1'b1;
        res.clear_rows = {1'b0, steady_pairs} + 1'b1;
        ref_base = bottom_px;
      end
    end else begin
      ref_base = bottom_px;
    end
    res.plane_rows = pairs_in_plane;
    first_col = 1'b0;
    open_column();
    return 1'b1;
  endfunction

  function automatic int spread(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic void push_pixel(input int d, input bit col_end, input bit frm_start);
    pixel_t p;
    p.depth = d[7:0];
    p.col_end = col_end;
    p.frm_start = frm_start;
    pixel_q.push_back(p);
  endfunction

  function automatic void add_column(input bit frm, input bit closed, input int len,
                                     input int base, input int slope, input int jitter,
                                     input int white_pct);
    int v;
    int white_left;
    white_left = 0;
    for (int i = 0; i < len; i++) begin
      v = base - slope * i + spread(jitter);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      if (white_left > 0) begin
        v = 255;
        white_left--;
      end else if ($urandom_range(0, 99) < white_pct) begin
        white_left = ($urandom_range(0, 99) < 15) ? $urandom_range(8, 30) : $urandom_range(0, 3);
      end
      push_pixel(v, closed && i == len - 1, frm && i == 0);
    end
  endfunction

  // flat seed column, then one column longer than the row limit with small steps
  function automatic void add_long_floor(input int b);
    push_pixel(b, 1'b0, 1'b1);
    push_pixel(b, 1'b0, 1'b0);
    push_pixel(b, 1'b1, 1'b0);
    for (int i = 0; i < MaxRows + 8; i++)
      push_pixel((i >= 2 && i[0]) ? b + 1 : b, i == MaxRows + 7, 1'b0);
  endfunction

  function automatic void random_columns(input int count);
    int  target;
    int  kind;
    int  len;
    bit  start;
    target = pixel_q.size() + count;
    while (pixel_q.size() < target) begin
      kind = $urandom_range(0, 99);
      start = 1'b0;
      if (need_frame || kind < 6) begin
        need_frame = 1'b0;
        start = 1'b1;
        gen_base = $urandom_range(10, 245);
        gen_slope = spread(3);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(2, 18);
      if (kind < 72) begin
        add_column(start, 1'b1, len, gen_base + spread(2), gen_slope + spread(1),
                   $urandom_range(0, 1), 8);
      end else if (kind < 82) begin
        add_column(start, 1'b1, $urandom_range(1, 12), $urandom_range(0, 255), spread(40),
                   60, 20);
      end else if (kind < 88) begin
        add_column(start, 1'b1, 1, $urandom_range(0, 255), 0, 0, 10);
      end else if (kind < 94) begin
        // drop a partial column: the next one restarts the frame
        add_column(start, 1'b0, $urandom_range(1, 6), gen_base, gen_slope, 1, 8);
        need_frame = 1'b1;
      end else begin
        add_column(start, 1'b1, 2, kind[0] ? 255 : 0, kind[0] ? 255 : -255, 0, 0);
      end
    end
  endfunction

  task automatic cfg_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic verify_reg(input logic [1:0] idx, input int want);
    logic [31:0] rd;
    cfg_access(1'b0, idx, '0, rd);
    if (rd !== want)
      report_mismatch($sformatf("register %0d read %0d, want %0d", idx, rd, want));
  endtask

  task automatic set_config(input int st, input int bt, input int mr, input int wl);
    logic [31:0] rd;
    cfg_access(1'b1, RegSlopeTol, st, rd);
    cfg_access(1'b1, RegBaseTol, bt, rd);
    cfg_access(1'b1, RegMinRows, mr, rd);
    cfg_access(1'b1, RegWhiteLim, wl, rd);
    tol_slope = 8'(st);
    tol_base = 8'(bt);
    min_rows = 10'(mr);
    white_limit = 10'(wl);
    verify_reg(RegSlopeTol, st);
    verify_reg(RegBaseTol, bt);
    verify_reg(RegMinRows, mr);
    verify_reg(RegWhiteLim, wl);
  endtask

  // hold until every request is taken and every result is back, then let the pipe settle
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || floor_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    pixel_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pixel_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        nxt = pixel_q.pop_front();
        in_valid <= 1'b1;
        in_depth <= nxt.depth;
        in_column_end <= nxt.col_end;
        in_frame_start <= nxt.frm_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk) begin
    if (holdoff_left > 0) begin
      out_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_seen != holdoff_req) begin
      holdoff_seen <= holdoff_req;
      holdoff_left <= HoldoffCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    floor_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (predict_pixel(in_depth, in_column_end, in_frame_start, want))
          floor_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (floor_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          want = floor_q.pop_front();
          if (out_floor_found !== want.floor_found)
            report_mismatch($sformatf("result %0d floor_found %0d, want %0d",
                                      results_seen, out_floor_found, want.floor_found));
          if (out_clear_rows !== want.clear_rows)
            report_mismatch($sformatf("result %0d clear_rows %0d, want %0d",
                                      results_seen, out_clear_rows, want.clear_rows));
          if (out_plane_rows !== want.plane_rows)
            report_mismatch($sformatf("result %0d plane_rows %0d, want %0d",
                                      results_seen, out_plane_rows, want.plane_rows));
        end
        results_seen++;
      end
    end
  end

  // watchdog: count cycles in which no request, result or register access completes
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("[depth_column_floor_detector] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    verify_reg(RegSlopeTol, 2);
    verify_reg(RegBaseTol, 2);
    verify_reg(RegMinRows, 5);
    verify_reg(RegWhiteLim, 20);

    // seed column, matching floor column, white extremes, single pixel, restart mid column
    add_column(1'b1, 1'b1, 6, 100, 2, 0, 0);
    add_column(1'b0, 1'b1, 7, 101, 2, 0, 0);
    push_pixel(0, 1'b0, 1'b0);
    push_pixel(255, 1'b0, 1'b0);
    push_pixel(255, 1'b0, 1'b0);
    push_pixel(0, 1'b1, 1'b0);
    push_pixel(200, 1'b1, 1'b0);
    push_pixel(50, 1'b0, 1'b0);
    push_pixel(52, 1'b0, 1'b0);
    push_pixel(10, 1'b1, 1'b1);
    wait_idle();

    set_config(6, 3, 4, 8);
    idle_pct = 60;
    random_columns(100);
    wait_idle();
    random_columns(100);
    wait_idle();

    set_config(0, 0, 0, 0);
    idle_pct = 0;
    stall_pct = 60;
    random_columns(200);
    @(negedge clk);
    holdoff_req++;
    wait_idle();

    set_config(255, 255, 512, 512);
    idle_pct = 12;
    stall_pct = 12;
    random_columns(150);
    wait_idle();

    set_config(2, 2, 3, 2);
    idle_pct = 0;
    stall_pct = 0;
    random_columns(50);
    add_long_floor($urandom_range(20, 200));
    random_columns(50);
    wait_idle();

    if (mismatches == 0)
      $display("[depth_column_floor_detector] OK");
    else
      $display("[depth_column_floor_detector] ERROR");
    $finish;
  end

endmodule
